[rtl/erm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and helpers of the extended Reinhard tone mapper.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int CHAN_W    = 32;
    localparam int CLIP_W    = 31;
    localparam int WEIGHT_W  = 17;
    localparam int LUM_W     = 32;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int DIV_REM_W = 64;
    localparam int DIV_QUO_W = 65;
    localparam int DIV_CNT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 17'd13933;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 17'd46871;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 17'd4732;

    localparam logic [15:0]       GAMMA_SCALE = 16'd65025;
    localparam logic [CODE_W-1:0] CODE_MAX    = 8'd255;
    localparam logic [32:0]       ONE_Q16     = 33'd65536;

    typedef struct packed {
        logic              action;
        logic              frame_start;
        logic [CLIP_W-1:0] red;
        logic [CLIP_W-1:0] green;
        logic [CLIP_W-1:0] blue;
    } item_t;

    typedef struct packed {
        logic                 valid;
        logic                 full;
    } queue_stat_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_QUO_W-1:0] quo_init;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic idle;
        logic div_wait;
    } back_stat_t;

    function automatic logic [CLIP_W-1:0] clip_channel(input logic [CHAN_W-1:0] raw);
        return raw[CHAN_W-1] ? '0 : raw[CLIP_W-1:0];
    endfunction

endpackage

[rtl/erm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_front
// Input side: takes beats, clips negative radiance and queues the items.
// ----------------------------------------------------------------------------
module erm_front #(
    parameter int QUEUE_DEPTH = erm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic                              s_frame_start,
    input  logic signed [erm_pkg::CHAN_W-1:0] s_in_red,
    input  logic signed [erm_pkg::CHAN_W-1:0] s_in_green,
    input  logic signed [erm_pkg::CHAN_W-1:0] s_in_blue,
    input  logic                              q_pop,
    output erm_pkg::item_t                    q_item,
    output erm_pkg::queue_stat_t              q_stat
);
    import erm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;
    item_t             in_item;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (count_reg != '0);

    assign in_item.action      = s_action;
    assign in_item.frame_start = s_frame_start;
    assign in_item.red         = clip_channel(s_in_red);
    assign in_item.green       = clip_channel(s_in_green);
    assign in_item.blue        = clip_channel(s_in_blue);

    assign q_item       = mem_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = !s_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/erm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erm_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  erm_pkg::div_req_t                 req,
    output erm_pkg::div_stat_t                stat,
    output logic [erm_pkg::DIV_QUO_W-1:0]     quotient
);
    import erm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_REM_W-1:0] div_reg, div_next;
    logic [DIV_REM_W:0]   rem_shift, rem_diff;
    logic                 ge;

    assign rem_shift = {rem_reg, quo_reg[DIV_QUO_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign ge        = (rem_shift >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            quo_next  = req.quo_init;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_diff[DIV_REM_W-1:0] : rem_shift[DIV_REM_W-1:0];
            quo_next = {quo_reg[DIV_QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

[rtl/erm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_back
// Execution side: luminance, peak tracking, tone curve, gamma and output.
// ----------------------------------------------------------------------------
module erm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [erm_pkg::WEIGHT_W-1:0]      weight_red,
    input  logic [erm_pkg::WEIGHT_W-1:0]      weight_green,
    input  logic [erm_pkg::WEIGHT_W-1:0]      weight_blue,
    input  erm_pkg::queue_stat_t              q_stat,
    input  erm_pkg::item_t                    q_item,
    output logic                              q_pop,
    output erm_pkg::div_req_t                 div_req,
    input  erm_pkg::div_stat_t                div_stat,
    input  logic [erm_pkg::DIV_QUO_W-1:0]     div_quo,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [erm_pkg::CODE_W-1:0]        m_out_red,
    output logic [erm_pkg::CODE_W-1:0]        m_out_green,
    output logic [erm_pkg::CODE_W-1:0]        m_out_blue,
    output erm_pkg::back_stat_t               back_stat
);
    import erm_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LUM0  = 5'd1;
    localparam logic [4:0] S_LUM1  = 5'd2;
    localparam logic [4:0] S_LUM2  = 5'd3;
    localparam logic [4:0] S_LUMF  = 5'd4;
    localparam logic [4:0] S_M2    = 5'd5;
    localparam logic [4:0] S_TDIV  = 5'd6;
    localparam logic [4:0] S_TWAIT = 5'd7;
    localparam logic [4:0] S_SDIV  = 5'd8;
    localparam logic [4:0] S_SWAIT = 5'd9;
    localparam logic [4:0] S_CHA   = 5'd10;
    localparam logic [4:0] S_CHB   = 5'd11;
    localparam logic [4:0] S_CHC   = 5'd12;
    localparam logic [4:0] S_CHD   = 5'd13;
    localparam logic [4:0] S_CHE   = 5'd14;
    localparam logic [4:0] S_CHF   = 5'd15;
    localparam logic [4:0] S_SQ    = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [4:0]        state_reg, state_next;
    item_t             item_reg, item_next;
    logic [49:0]       acc_reg, acc_next;
    logic [LUM_W-1:0]  lum_reg, lum_next;
    logic [LUM_W-1:0]  peak_reg, peak_next;
    logic [63:0]       m2_reg, m2_next;
    logic [31:0]       t_reg, t_next;
    logic [48:0]       s_reg, s_next;
    logic [1:0]        ch_reg, ch_next;
    logic [54:0]       pa_reg, pa_next;
    logic [55:0]       pb_reg, pb_next;
    logic [47:0]       p_reg, p_next;
    logic [39:0]       qh_reg, qh_next;
    logic [39:0]       ql_reg, ql_next;
    logic [15:0]       z_reg, z_next;
    logic [7:0]        root_reg, root_next;
    logic [2:0]        bit_reg, bit_next;
    logic [CODE_W-1:0] res_reg [3];
    logic [CODE_W-1:0] res_next [3];
    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] out_red_reg, out_red_next;
    logic [CODE_W-1:0] out_green_reg, out_green_next;
    logic [CODE_W-1:0] out_blue_reg, out_blue_next;

    logic [WEIGHT_W-1:0] mul_w;
    logic [CLIP_W-1:0]   mul_x;
    logic [47:0]         lum_prod;
    logic [CLIP_W-1:0]   x_sel;
    logic [LUM_W-1:0]    lum_c;
    logic [LUM_W-1:0]    peak_base;
    logic [79:0]         p_full;
    logic [63:0]         z_sum;
    logic [7:0]          cand;
    logic [15:0]         cand_sq;
    logic [32:0]         num_c, den_c;
    logic                next_is_out;

    always_comb begin
        case (state_reg)
            S_LUM0:  begin mul_w = weight_red;   mul_x = item_reg.red;   end
            S_LUM1:  begin mul_w = weight_green; mul_x = item_reg.green; end
            default: begin mul_w = weight_blue;  mul_x = item_reg.blue;  end
        endcase
        case (ch_reg)
            CH_RED:   x_sel = item_reg.red;
            CH_GREEN: x_sel = item_reg.green;
            default:  x_sel = item_reg.blue;
        endcase
    end

    assign lum_prod    = mul_w * mul_x;
    assign lum_c       = (acc_reg[49:48] != 2'b00) ? '1 : acc_reg[47:16];
    assign peak_base   = item_reg.frame_start ? '0 : peak_reg;
    assign p_full      = {pb_reg, 24'b0} + {25'b0, pa_reg};
    assign z_sum       = {qh_reg, 24'b0} + {24'b0, ql_reg};
    assign cand        = root_reg | (8'd1 << bit_reg);
    assign cand_sq     = cand * cand;
    assign num_c       = ONE_Q16 + {1'b0, t_reg};
    assign den_c       = ONE_Q16 + {1'b0, lum_reg};
    assign next_is_out = (ch_reg == CH_BLUE);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        lum_next       = lum_reg;
        peak_next      = peak_reg;
        m2_next        = m2_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        ch_next        = ch_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        p_next         = p_reg;
        qh_next        = qh_reg;
        ql_next        = ql_reg;
        z_next         = z_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        q_pop          = 1'b0;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_stat.valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_LUM0;
                end
            end
            S_LUM0: begin
                acc_next   = {2'b00, lum_prod};
                state_next = S_LUM1;
            end
            S_LUM1: begin
                acc_next   = acc_reg + {2'b00, lum_prod};
                state_next = S_LUM2;
            end
            S_LUM2: begin
                acc_next   = acc_reg + {2'b00, lum_prod};
                state_next = S_LUMF;
            end
            S_LUMF: begin
                lum_next = lum_c;
                if (!item_reg.action) begin
                    peak_next  = (lum_c > peak_base) ? lum_c : peak_base;
                    state_next = S_IDLE;
                end else if (item_reg.red == '0 && item_reg.green == '0
                             && item_reg.blue == '0) begin
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_M2;
                end
            end
            S_M2: begin
                m2_next    = peak_reg * peak_reg;
                state_next = S_TDIV;
            end
            S_TDIV: begin
                if (peak_reg == '0 || {32'b0, lum_reg} >= m2_reg) begin
                    t_next     = '1;
                    state_next = S_SDIV;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.iters    = DIV_CNT_W'(32);
                    div_req.rem_init = {32'b0, lum_reg};
                    div_req.quo_init = '0;
                    div_req.divisor  = m2_reg;
                    state_next       = S_TWAIT;
                end
            end
            S_TWAIT: begin
                if (div_stat.done) begin
                    t_next     = div_quo[31:0];
                    state_next = S_SDIV;
                end
            end
            S_SDIV: begin
                div_req.start    = 1'b1;
                div_req.iters    = DIV_CNT_W'(DIV_QUO_W);
                div_req.rem_init = '0;
                div_req.quo_init = {num_c, 32'b0};
                div_req.divisor  = {31'b0, den_c};
                state_next       = S_SWAIT;
            end
            S_SWAIT: begin
                if (div_stat.done) begin
                    s_next     = div_quo[48:0];
                    ch_next    = CH_RED;
                    state_next = S_CHA;
                end
            end
            S_CHA: begin
                pa_next    = s_reg[23:0] * x_sel;
                state_next = S_CHB;
            end
            S_CHB: begin
                pb_next    = s_reg[48:24] * x_sel;
                state_next = S_CHC;
            end
            S_CHC: begin
                if (p_full[79:48] != '0) begin
                    res_next[ch_reg] = CODE_MAX;
                    ch_next          = ch_reg + 1'b1;
                    state_next       = next_is_out ? S_OUT : S_CHA;
                end else begin
                    p_next     = p_full[47:0];
                    state_next = S_CHD;
                end
            end
            S_CHD: begin
                qh_next    = p_reg[47:24] * GAMMA_SCALE;
                state_next = S_CHE;
            end
            S_CHE: begin
                ql_next    = p_reg[23:0] * GAMMA_SCALE;
                state_next = S_CHF;
            end
            S_CHF: begin
                z_next     = z_sum[63:48];
                root_next  = '0;
                bit_next   = 3'd7;
                state_next = S_SQ;
            end
            S_SQ: begin
                if (cand_sq <= z_reg) begin
                    root_next = cand;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 3'd0) begin
                    res_next[ch_reg] = (cand_sq <= z_reg) ? cand : root_reg;
                    ch_next          = ch_reg + 1'b1;
                    state_next       = next_is_out ? S_OUT : S_CHA;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_red_next   = res_reg[0];
                    out_green_next = res_reg[1];
                    out_blue_next  = res_reg[2];
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        acc_reg       <= acc_next;
        lum_reg       <= lum_next;
        m2_reg        <= m2_next;
        t_reg         <= t_next;
        s_reg         <= s_next;
        ch_reg        <= ch_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        p_reg         <= p_next;
        qh_reg        <= qh_next;
        ql_reg        <= ql_next;
        z_reg         <= z_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        res_reg       <= res_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_out_red          = out_red_reg;
    assign m_out_green        = out_green_reg;
    assign m_out_blue         = out_blue_reg;
    assign back_stat.idle     = (state_reg == S_IDLE);
    assign back_stat.div_wait = (state_reg == S_TWAIT) || (state_reg == S_SWAIT);

endmodule

[rtl/extended_reinhard_tone_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_reinhard_tone_mapper
// Two-pass extended Reinhard tone mapper with square-root gamma.
// ----------------------------------------------------------------------------
// Measure beats update the frame peak luminance in the execution stage; map
// beats compute the luminance, the L/Lmax^2 quotient, the scale factor and then
// each color channel in turn, and an all-black pixel goes straight to output.
// The shared bit-per-cycle divider computes both quotients. A small input
// queue and an output register decouple both sides.
// ----------------------------------------------------------------------------
module extended_reinhard_tone_mapper #(
    parameter int QUEUE_DEPTH = erm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic                                s_frame_start,
    input  logic signed [erm_pkg::CHAN_W-1:0]   s_in_red,
    input  logic signed [erm_pkg::CHAN_W-1:0]   s_in_green,
    input  logic signed [erm_pkg::CHAN_W-1:0]   s_in_blue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [erm_pkg::CODE_W-1:0]          m_out_red,
    output logic [erm_pkg::CODE_W-1:0]          m_out_green,
    output logic [erm_pkg::CODE_W-1:0]          m_out_blue,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [erm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [erm_pkg::WEIGHT_W-1:0]        cfg_data
);
    import erm_pkg::*;

    logic [WEIGHT_W-1:0] weight_red_reg, weight_red_next;
    logic [WEIGHT_W-1:0] weight_green_reg, weight_green_next;
    logic [WEIGHT_W-1:0] weight_blue_reg, weight_blue_next;

    item_t                q_item;
    queue_stat_t          q_stat;
    logic                 q_pop;
    div_req_t             div_req;
    div_stat_t            div_stat;
    logic [DIV_QUO_W-1:0] div_quo;
    back_stat_t           back_stat;

    assign cfg_ready = 1'b1;

    always_comb begin
        weight_red_next   = weight_red_reg;
        weight_green_next = weight_green_reg;
        weight_blue_next  = weight_blue_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WEIGHT_RED:   weight_red_next   = cfg_data;
                REG_WEIGHT_GREEN: weight_green_next = cfg_data;
                REG_WEIGHT_BLUE:  weight_blue_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_red_reg   <= WEIGHT_RED_RST;
            weight_green_reg <= WEIGHT_GREEN_RST;
            weight_blue_reg  <= WEIGHT_BLUE_RST;
        end else begin
            weight_red_reg   <= weight_red_next;
            weight_green_reg <= weight_green_next;
            weight_blue_reg  <= weight_blue_next;
        end
    end

    erm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_frame_start (s_frame_start),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .q_stat        (q_stat)
    );

    erm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    erm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .weight_red   (weight_red_reg),
        .weight_green (weight_green_reg),
        .weight_blue  (weight_blue_reg),
        .q_stat       (q_stat),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_stat     (div_stat),
        .div_quo      (div_quo),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .back_stat    (back_stat)
    );

    // an accepted beat is queued by the next edge
    a_queue_holds_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> q_stat.valid)
        else $error("accepted beat not queued");

    // the divider only finishes while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> back_stat.div_wait)
        else $error("divider result not awaited");

    // the divider is never restarted while busy
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !div_req.start)
        else $error("divider restarted while busy");

    // the sequencer never pops while working on an item
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> back_stat.idle && q_stat.valid)
        else $error("queue popped outside idle");

endmodule

[verif/erm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_checker
// Watches the pixel, display and weight channels of the tone mapper, predicts
// each display beat from the accepted pixel beats and compares in order.
// ----------------------------------------------------------------------------
module erm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_action,
    input  logic                              s_frame_start,
    input  logic [erm_pkg::CHAN_W-1:0]        s_in_red,
    input  logic [erm_pkg::CHAN_W-1:0]        s_in_green,
    input  logic [erm_pkg::CHAN_W-1:0]        s_in_blue,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [erm_pkg::CODE_W-1:0]        m_out_red,
    input  logic [erm_pkg::CODE_W-1:0]        m_out_green,
    input  logic [erm_pkg::CODE_W-1:0]        m_out_blue,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [erm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [erm_pkg::WEIGHT_W-1:0]      cfg_data,
    output int                                errors,
    output int                                pending,
    output int                                shown
);
    import erm_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
    } display_t;

    display_t          display_q[$];
    logic [WEIGHT_W-1:0] w_red, w_green, w_blue;
    logic [LUM_W-1:0]    peak;

    function automatic logic [CLIP_W-1:0] positive_part(logic [CHAN_W-1:0] raw);
        return raw[CHAN_W-1] ? '0 : raw[CLIP_W-1:0];
    endfunction

    function automatic logic [LUM_W-1:0] weighted_lum(logic [CLIP_W-1:0] r,
            logic [CLIP_W-1:0] g, logic [CLIP_W-1:0] b);
        logic [63:0] sum;
        sum = (64'(w_red) * r + 64'(w_green) * g + 64'(w_blue) * b) >> 16;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic [CODE_W-1:0] gamma_code(logic [CLIP_W-1:0] x,
            logic [127:0] scale);
        logic [127:0] p, z;
        logic [15:0]  root, cand;
        if (x == 0) return '0;
        p = scale * x;
        if (p >= (128'd1 << 48)) return CODE_MAX;
        z = (p * 65025) >> 48;
        root = 0;
        for (int i = 7; i >= 0; i--) begin
            cand = root | (16'd1 << i);
            if (128'(cand) * cand <= z) root = cand;
        end
        return root[7:0];
    endfunction

    function automatic display_t map_pixel(logic [CLIP_W-1:0] r, logic [CLIP_W-1:0] g,
            logic [CLIP_W-1:0] b, logic [LUM_W-1:0] lum);
        logic [127:0] m2, t, num, den, scale;
        display_t d;
        d = '0;
        if (r == 0 && g == 0 && b == 0) return d;
        m2 = 128'(peak) * peak;
        if (peak == 0 || 128'(lum) >= m2) t = 128'hFFFF_FFFF;
        else t = (128'(lum) << 32) / m2;
        num   = 128'd65536 + t;
        den   = 128'd65536 + lum;
        scale = (num << 32) / den;
        d.red   = gamma_code(r, scale);
        d.green = gamma_code(g, scale);
        d.blue  = gamma_code(b, scale);
        return d;
    endfunction

    task automatic report(string what, int exp_v, int got_v);
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    assign pending = display_q.size();

    always @(posedge aclk) begin
        logic [CLIP_W-1:0] r, g, b;
        logic [LUM_W-1:0]  lum;
        display_t          e;
        if (!aresetn) begin
            display_q.delete();
            w_red   <= WEIGHT_RED_RST;
            w_green <= WEIGHT_GREEN_RST;
            w_blue  <= WEIGHT_BLUE_RST;
            peak    = '0;
        end else begin
            if (s_valid && s_ready) begin
                r = positive_part(s_in_red);
                g = positive_part(s_in_green);
                b = positive_part(s_in_blue);
                lum = weighted_lum(r, g, b);
                if (!s_action) begin
                    if (s_frame_start) peak = '0;
                    if (lum > peak) peak = lum;
                end else begin
                    display_q.push_back(map_pixel(r, g, b, lum));
                end
            end
            if (m_valid && m_ready) begin
                shown++;
                if (display_q.size() == 0) begin
                    report("display beat with nothing expected", 0, 1);
                end else begin
                    e = display_q.pop_front();
                    if (m_out_red != e.red) report("out_red", e.red, m_out_red);
                    if (m_out_green != e.green) report("out_green", e.green, m_out_green);
                    if (m_out_blue != e.blue) report("out_blue", e.blue, m_out_blue);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WEIGHT_RED: begin
                        w_red <= cfg_data;
                    end
                    REG_WEIGHT_GREEN: begin
                        w_green <= cfg_data;
                    end
                    REG_WEIGHT_BLUE: begin
                        w_blue <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    initial begin
        errors = 0;
        shown  = 0;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Tone mapper testbench: directed corner pixels, then two-pass frames with
// random radiance under several weight settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import erm_pkg::*;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    logic                  s_action = 0;
    logic                  s_frame_start = 0;
    logic [CHAN_W-1:0]     s_in_red = '0, s_in_green = '0, s_in_blue = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic [CODE_W-1:0]     m_out_red, m_out_green, m_out_blue;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WEIGHT_W-1:0]   cfg_data = '0;
    int                    errors, pending, shown;
    int                    sent = 0;
    int                    frames = 0;
    bit                    calm = 0;
    logic [CHAN_W-1:0]     frame_px[64][3];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    extended_reinhard_tone_mapper dut (.*);

    erm_checker chk (.*);

    initial begin
        #50_000_000;
        $display("extended_reinhard_tone_mapper: mismatch");
        $finish;
    end

    always begin
        int stall;
        @(posedge aclk);
        if (aresetn) begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send(logic act, logic fs, logic [CHAN_W-1:0] r,
            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1;
        s_action      <= act;
        s_frame_start <= fs;
        s_in_red      <= r;
        s_in_green    <= g;
        s_in_blue     <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [CHAN_W-1:0] radiance();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            4: return -$urandom_range(1, 32'h0010_0000);
            5: return $urandom_range(0, 32'h0000_0100);
            6: return $urandom_range(0, 32'h0001_0000);
            default: return $urandom_range(0, 32'h0040_0000);
        endcase
    endfunction

    task automatic run_frames(int budget);
        int n, k;
        while (budget > 0) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0) begin
                send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     radiance(), radiance(), radiance());
                budget--;
            end else begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) begin
                    for (int c = 0; c < 3; c++) frame_px[i][c] = radiance();
                    send(0, i == 0, frame_px[i][0], frame_px[i][1], frame_px[i][2]);
                end
                for (int i = 0; i < n; i++) begin
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : i;
                    send(1, 1'($urandom_range(0, 1)), frame_px[k][0], frame_px[k][1],
                         frame_px[k][2]);
                end
                budget -= 2 * n;
                frames++;
            end
        end
        calm = 0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // corners: zero peak, black, extremes, frame start on map
        send(1, 0, 32'd100, 32'd200, 32'd300);
        send(1, 1, '0, '0, '0);
        send(1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
        send(0, 1, 32'd1, 32'd1, 32'd1);
        send(1, 0, 32'd1, 32'd2, 32'd3);
        send(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(1, 0, 32'h0001_0000, 32'h0000_8000, 32'h0000_0001);
        send(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send(1, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send(0, 1, 32'h0002_0000, 32'h8000_0000, 32'h0000_4000);
        send(1, 0, 32'h0000_4000, 32'h0002_0000, 32'hFFFF_0000);
        send(1, 0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send(0, 1, 32'h0, 32'h0, 32'h0);
        send(1, 0, 32'h0000_0010, 32'h0, 32'h0);
        drain();

        run_frames(320);
        drain();
        write_weight(REG_WEIGHT_RED, 17'd65536);
        write_weight(REG_WEIGHT_GREEN, 17'd65536);
        write_weight(REG_WEIGHT_BLUE, 17'd65536);
        run_frames(320);
        drain();
        write_weight(REG_WEIGHT_RED, 17'd0);
        write_weight(REG_WEIGHT_GREEN, 17'd0);
        write_weight(REG_WEIGHT_BLUE, 17'd0);
        run_frames(320);
        drain();
        write_weight(REG_WEIGHT_RED, 17'h1FFFF);
        write_weight(REG_WEIGHT_GREEN, WEIGHT_W'($urandom));
        write_weight(REG_WEIGHT_BLUE, 17'h1FFFF);
        write_weight(2'd3, 17'd0);
        run_frames(320);
        drain();
        write_weight(REG_WEIGHT_RED, WEIGHT_W'($urandom));
        write_weight(REG_WEIGHT_GREEN, WEIGHT_W'($urandom));
        write_weight(REG_WEIGHT_BLUE, WEIGHT_W'($urandom));
        run_frames(320);
        drain();
        write_weight(REG_WEIGHT_RED, WEIGHT_RED_RST);
        write_weight(REG_WEIGHT_GREEN, WEIGHT_GREEN_RST);
        write_weight(REG_WEIGHT_BLUE, WEIGHT_BLUE_RST);
        run_frames(320);
        drain();

        $display("covered %0d pixel beats in %0d frames, %0d display beats checked",
                 sent, frames, shown);
        $display("weights: reset, all one, all zero, saturating and random settings");
        if (errors == 0 && pending == 0) begin
            $display("extended_reinhard_tone_mapper: match");
        end else begin
            $display("extended_reinhard_tone_mapper: mismatch");
        end
        $finish;
    end

endmodule
